@@ rtl/core/spi_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spi_pkg: shared types and constants of the segment/plane intersector
// Coordinate, plane and queue entry types used by the front end, the queue
// and the back end.
// ----------------------------------------------------------------------------
package spi_pkg;

  localparam int DW          = 52;  // signed distance width
  localparam int MW          = 32;  // normalized divisor width
  localparam int QW          = 31;  // quotient width, Q1.30
  localparam int DIV_STAGES  = 31;  // one quotient bit per stage
  localparam int SHW         = 5;   // normalize shift count width
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_AW     = 2;
  localparam int FIFO_CW     = 3;
  localparam int AXES        = 3;

  typedef logic signed [31:0] coord_t;

  typedef enum logic [1:0] {
    REG_A = 2'd0,
    REG_B = 2'd1,
    REG_C = 2'd2,
    REG_D = 2'd3
  } reg_idx_t;

  typedef struct packed {
    coord_t a;
    coord_t b;
    coord_t c;
    coord_t d;
  } plane_t;

  typedef struct packed {
    coord_t sx;
    coord_t sy;
    coord_t sz;
    coord_t ex;
    coord_t ey;
    coord_t ez;
  } seg_t;

  // one classified segment between front and back
  typedef struct packed {
    seg_t                 seg;
    logic signed [DW-1:0] d1;
    logic signed [DW-1:0] d2;
    logic                 miss;
  } item_t;

  // full-precision product of a coefficient and a coordinate
  function automatic logic signed [63:0] mul_q(input coord_t k, input coord_t v);
    logic signed [63:0] p;
    p = k * v;
    return p;
  endfunction

  // floored Q16.16 product, sign extended to distance width
  function automatic logic signed [DW-1:0] floor_q16(input logic signed [63:0] p);
    logic signed [63:0] s;
    s = p >>> 16;
    return DW'(s);
  endfunction

endpackage

@@ rtl/core/segment_plane_intersection.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_plane_intersection: segment versus plane crossing in Q16.16
// Usage:
//   Program plane_a..plane_d over the APB port (byte addresses 0, 4, 8, 12)
//   while no segment is in flight. Present a segment on the in_ ports with
//   start high; it is taken when busy is low. busy stays low in normal use,
//   so one segment per cycle may be issued.
//   Every segment gives exactly one result on the out_ ports, marked by a
//   single-cycle out_valid pulse: out_hit and the crossing point, or zeros
//   for a miss. Results leave in issue order.
//   From accept to out_valid a segment passes the front stages (products,
//   distance sum), the queue register, the normalize stages, 31 divider
//   stages (one quotient bit each) and the interpolation stages. Throughput
//   is one segment per cycle, set by the fully pipelined divider.
//   The receiver cannot stall; results must be captured when out_valid is
//   high. Reset clears the plane registers to zero and empties the pipeline.
// ----------------------------------------------------------------------------
module segment_plane_intersection (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [3:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready,
  input  logic            start,
  output logic            busy,
  input  spi_pkg::coord_t in_start_x,
  input  spi_pkg::coord_t in_start_y,
  input  spi_pkg::coord_t in_start_z,
  input  spi_pkg::coord_t in_end_x,
  input  spi_pkg::coord_t in_end_y,
  input  spi_pkg::coord_t in_end_z,
  output logic            out_valid,
  output logic            out_hit,
  output spi_pkg::coord_t out_hit_x,
  output spi_pkg::coord_t out_hit_y,
  output spi_pkg::coord_t out_hit_z
);
  import spi_pkg::*;

  plane_t   plane_r;
  reg_idx_t idx;
  logic     wr_en;
  logic     take;
  seg_t     seg_in;
  logic     push;
  item_t    f_item;
  logic     q_vld;
  item_t    q_item;
  logic     q_afull;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;

  // hold plane registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plane_r <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_A: plane_r.a <= pwdata;
        REG_B: plane_r.b <= pwdata;
        REG_C: plane_r.c <= pwdata;
        REG_D: plane_r.d <= pwdata;
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (idx)
      REG_A: prdata = plane_r.a;
      REG_B: prdata = plane_r.b;
      REG_C: prdata = plane_r.c;
      REG_D: prdata = plane_r.d;
      default: prdata = '0;
    endcase
  end

  assign busy = q_afull;
  assign take = start && !busy;

  always_comb begin
    seg_in.sx = in_start_x;
    seg_in.sy = in_start_y;
    seg_in.sz = in_start_z;
    seg_in.ex = in_end_x;
    seg_in.ey = in_end_y;
    seg_in.ez = in_end_z;
  end

  spi_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .plane (plane_r),
    .take  (take),
    .seg_in(seg_in),
    .push  (push),
    .item  (f_item)
  );

  spi_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .wdata      (f_item),
    .pop        (1'b1),
    .not_empty  (q_vld),
    .rdata      (q_item),
    .almost_full(q_afull)
  );

  spi_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_vld (q_vld),
    .item   (q_item),
    .out_vld(out_valid),
    .hit    (out_hit),
    .hit_x  (out_hit_x),
    .hit_y  (out_hit_y),
    .hit_z  (out_hit_z)
  );

  // a miss reports a zero point
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_hit_x == 0 && out_hit_y == 0 && out_hit_z == 0)
    else $error("miss transaction carries a nonzero point");

  // the queue never backs up into the input
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("queue filled up");

  // a write to plane_a lands in the register
  a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en && idx == REG_A |=> plane_r.a == $past(pwdata))
    else $error("plane_a write lost");

endmodule

@@ rtl/core/spi_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spi_front: distance and classification front end
// Multiplies both endpoints against the plane, sums the floored products and
// decides whether the segment misses the plane.
// ----------------------------------------------------------------------------
module spi_front (
  input  logic            clk,
  input  logic            rst_n,
  input  spi_pkg::plane_t plane,
  input  logic            take,
  input  spi_pkg::seg_t   seg_in,
  output logic            push,
  output spi_pkg::item_t  item
);
  import spi_pkg::*;

  logic               v0_r;
  seg_t               seg0_r;
  logic signed [63:0] p_r   [6];
  logic signed [63:0] p_nxt [6];
  logic               push_r;
  item_t              item_r;
  item_t              item_nxt;
  logic signed [DW-1:0] d1;
  logic signed [DW-1:0] d2;

  // form the six products
  always_comb begin
    p_nxt[0] = mul_q(plane.a, seg_in.sx);
    p_nxt[1] = mul_q(plane.b, seg_in.sy);
    p_nxt[2] = mul_q(plane.c, seg_in.sz);
    p_nxt[3] = mul_q(plane.a, seg_in.ex);
    p_nxt[4] = mul_q(plane.b, seg_in.ey);
    p_nxt[5] = mul_q(plane.c, seg_in.ez);
  end

  // sum distances and classify
  always_comb begin
    d1 = floor_q16(p_r[0]) + floor_q16(p_r[1]) + floor_q16(p_r[2]) + DW'(plane.d);
    d2 = floor_q16(p_r[3]) + floor_q16(p_r[4]) + floor_q16(p_r[5]) + DW'(plane.d);
    item_nxt.seg  = seg0_r;
    item_nxt.d1   = d1;
    item_nxt.d2   = d2;
    item_nxt.miss = (d1 == d2) || (d1 > 0 && d2 > 0) || (d1 < 0 && d2 < 0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r   <= 1'b0;
      push_r <= 1'b0;
    end else begin
      v0_r   <= take;
      push_r <= v0_r;
    end
    seg0_r <= seg_in;
    for (int i = 0; i < 6; i++) begin
      p_r[i] <= p_nxt[i];
    end
    item_r <= item_nxt;
  end

  assign push = push_r;
  assign item = item_r;

endmodule

@@ rtl/core/spi_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spi_fifo: short queue between front and back
// Holds classified segments; the back end drains one entry per cycle.
// ----------------------------------------------------------------------------
module spi_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  spi_pkg::item_t wdata,
  input  logic           pop,
  output logic           not_empty,
  output spi_pkg::item_t rdata,
  output logic           almost_full
);
  import spi_pkg::*;

  item_t              mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r;
  logic [FIFO_AW-1:0] rd_ptr_r;
  logic [FIFO_CW-1:0] cnt_r;
  logic               do_pop;

  assign do_pop      = pop && (cnt_r != '0);
  assign not_empty   = (cnt_r != '0);
  assign rdata       = mem_r[rd_ptr_r];
  assign almost_full = (cnt_r >= FIFO_CW'(FIFO_DEPTH - 2));

  // advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_r + FIFO_CW'(push) - FIFO_CW'(do_pop);
    end
    if (push) mem_r[wr_ptr_r] <= wdata;
  end

endmodule

@@ rtl/core/spi_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spi_back: fraction and interpolation back end
// Normalizes the distances, divides them one quotient bit per stage and
// interpolates the crossing point on all three axes.
// ----------------------------------------------------------------------------
module spi_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_vld,
  input  spi_pkg::item_t item,
  output logic           out_vld,
  output logic           hit,
  output spi_pkg::coord_t hit_x,
  output spi_pkg::coord_t hit_y,
  output spi_pkg::coord_t hit_z
);
  import spi_pkg::*;

  typedef struct packed {
    seg_t          seg;
    logic          miss;
    logic [MW-1:0] m;
    logic [MW:0]   r;
    logic [QW-1:0] q;
  } divst_t;

  // magnitude, shift and normalize stages
  logic          b0_v_r, b1_v_r, b2_v_r;
  seg_t          b0_seg_r, b1_seg_r, b2_seg_r;
  logic          b0_miss_r, b1_miss_r, b2_miss_r;
  logic [DW-1:0] b0_n_r, b0_m_r, b1_n_r, b1_m_r;
  logic [SHW-1:0] b1_sh_r, sh_nxt;
  logic [MW-1:0] b2_n_r, b2_m_r;
  logic [DW-1:0] n_nxt, m_nxt;

  always_comb begin
    n_nxt = item.d1 < 0 ? DW'(-item.d1) : DW'(item.d1);
    m_nxt = n_nxt + (item.d2 < 0 ? DW'(-item.d2) : DW'(item.d2));
  end

  // locate the leading one above the divisor width
  always_comb begin
    sh_nxt = '0;
    for (int i = 0; i < DW - MW; i++) begin
      if (b0_m_r[MW+i]) sh_nxt = SHW'(i + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b0_v_r <= 1'b0;
      b1_v_r <= 1'b0;
      b2_v_r <= 1'b0;
    end else begin
      b0_v_r <= in_vld;
      b1_v_r <= b0_v_r;
      b2_v_r <= b1_v_r;
    end
    b0_seg_r  <= item.seg;
    b0_miss_r <= item.miss;
    b0_n_r    <= n_nxt;
    b0_m_r    <= m_nxt;
    b1_seg_r  <= b0_seg_r;
    b1_miss_r <= b0_miss_r;
    b1_n_r    <= b0_n_r;
    b1_m_r    <= b0_m_r;
    b1_sh_r   <= sh_nxt;
    b2_seg_r  <= b1_seg_r;
    b2_miss_r <= b1_miss_r;
    b2_n_r    <= MW'(b1_n_r >> b1_sh_r);
    b2_m_r    <= MW'(b1_m_r >> b1_sh_r);
  end

  // restoring divider, one quotient bit per stage
  divst_t                dv_r   [DIV_STAGES];
  divst_t                dv_nxt [DIV_STAGES];
  logic [DIV_STAGES-1:0] dvv_r;
  logic [MW:0]           r2     [DIV_STAGES];

  always_comb begin
    dv_nxt[0].seg  = b2_seg_r;
    dv_nxt[0].miss = b2_miss_r;
    dv_nxt[0].m    = b2_m_r;
    dv_nxt[0].q    = QW'(b2_n_r == b2_m_r);
    dv_nxt[0].r    = (b2_n_r == b2_m_r) ? '0 : {1'b0, b2_n_r};
    r2[0]          = '0;
    for (int k = 1; k < DIV_STAGES; k++) begin
      r2[k]          = {dv_r[k-1].r[MW-1:0], 1'b0};
      dv_nxt[k].seg  = dv_r[k-1].seg;
      dv_nxt[k].miss = dv_r[k-1].miss;
      dv_nxt[k].m    = dv_r[k-1].m;
      if (r2[k] >= {1'b0, dv_r[k-1].m}) begin
        dv_nxt[k].r = r2[k] - {1'b0, dv_r[k-1].m};
        dv_nxt[k].q = {dv_r[k-1].q[QW-2:0], 1'b1};
      end else begin
        dv_nxt[k].r = r2[k];
        dv_nxt[k].q = {dv_r[k-1].q[QW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dvv_r <= '0;
    end else begin
      dvv_r <= {dvv_r[DIV_STAGES-2:0], b2_v_r};
    end
    for (int k = 0; k < DIV_STAGES; k++) begin
      dv_r[k] <= dv_nxt[k];
    end
  end

  // interpolate: partial products per axis
  divst_t             dl;
  coord_t             s_ax [AXES];
  coord_t             e_ax [AXES];
  logic signed [32:0] delta [AXES];
  logic [32:0]        dmag [AXES];
  logic               l0_v_r, l0_miss_r;
  coord_t             l0_s_r  [AXES];
  logic               l0_neg_r [AXES];
  logic [46:0]        l0_pl_r [AXES];
  logic [47:0]        l0_ph_r [AXES];

  assign dl = dv_r[DIV_STAGES-1];

  always_comb begin
    s_ax[0] = dl.seg.sx;
    s_ax[1] = dl.seg.sy;
    s_ax[2] = dl.seg.sz;
    e_ax[0] = dl.seg.ex;
    e_ax[1] = dl.seg.ey;
    e_ax[2] = dl.seg.ez;
    for (int i = 0; i < AXES; i++) begin
      delta[i] = 33'(e_ax[i]) - 33'(s_ax[i]);
      dmag[i]  = delta[i][32] ? 33'(-delta[i]) : 33'(delta[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l0_v_r <= 1'b0;
    end else begin
      l0_v_r <= dvv_r[DIV_STAGES-1];
    end
    l0_miss_r <= dl.miss;
    for (int i = 0; i < AXES; i++) begin
      l0_s_r[i]   <= s_ax[i];
      l0_neg_r[i] <= delta[i][32];
      l0_pl_r[i]  <= 47'(dl.q) * 47'(dmag[i][15:0]);
      l0_ph_r[i]  <= 48'(dl.q) * 48'(dmag[i][32:16]);
    end
  end

  // combine, round and saturate
  logic [63:0]        prod [AXES];
  logic [33:0]        off  [AXES];
  logic signed [34:0] res  [AXES];
  coord_t             sat  [AXES];
  logic               out_vld_r, hit_r;
  coord_t             hx_r, hy_r, hz_r;

  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      prod[i] = {l0_ph_r[i], 16'b0} + 64'(l0_pl_r[i]) + 64'(32'h2000_0000);
      off[i]  = prod[i][63:30];
      res[i]  = l0_neg_r[i] ? 35'(l0_s_r[i]) - 35'(off[i]) : 35'(l0_s_r[i]) + 35'(off[i]);
      if (res[i] > 35'sd2147483647) sat[i] = 32'sh7FFF_FFFF;
      else if (res[i] < -35'sd2147483648) sat[i] = 32'sh8000_0000;
      else sat[i] = coord_t'(res[i][31:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= l0_v_r;
    end
    hit_r <= !l0_miss_r;
    hx_r  <= l0_miss_r ? '0 : sat[0];
    hy_r  <= l0_miss_r ? '0 : sat[1];
    hz_r  <= l0_miss_r ? '0 : sat[2];
  end

  assign out_vld = out_vld_r;
  assign hit     = hit_r;
  assign hit_x   = hx_r;
  assign hit_y   = hy_r;
  assign hit_z   = hz_r;

endmodule
